/* rtl/imc_pkg.sv */
package imc_pkg;

   localparam int RAW_W  = 16;
   localparam int CORR_W = 17;
   localparam int SUM_W  = 33;
   localparam int SQ_W   = 33;
   localparam int DIV_W  = 32;
   localparam int RAD_W  = 62;
   localparam int ROOT_W = 31;
   localparam int ARG_W  = 36;
   localparam int ZACC_W = 27;
   localparam int ATAN_W = 22;
   localparam int NUM_AXES = 6;
   localparam int ARG_SHIFT = 14;

   typedef struct packed {
      logic acc_en;
      logic corr_en;
      logic sq_en;
      logic div_start;
   } lane_ctl_type;

   // Arctangent of 2^-i in degrees with 16 fraction bits, rounded to nearest.
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/imu_offset_calibrate_and_tilt.sv */
// Measure item: the result waits on the 31-step square root of the y-z term
// followed by the pitch CORDIC, and then on a free output register.
// Calibration item: the item that closes a run waits for the six parallel
// 32-step mean dividers. One item is in work at a time, so a measure item holds
// the input until its result is loaded into the output register.
// Synchronous reset clears sums, count, offsets and the calibrated flag.
module imu_offset_calibrate_and_tilt import imc_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // raw_ax, raw_ay, raw_az, raw_gx, raw_gy, raw_gz
   input  logic [95:0]  req_tdata,
   // action
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, acc_magnitude, roll_deg, pitch_deg
   output logic [151:0] rsp_tdata,
   // calibrated
   output logic [0:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic REG_CAL_SAMPLES = 1'b0;
   localparam logic REG_ONE_G       = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_DIV_START  = 7'b0000010,
      ST_DIV_RUN    = 7'b0000100,
      ST_SQ         = 7'b0001000,
      ST_MATH_START = 7'b0010000,
      ST_MATH_WAIT  = 7'b0100000,
      ST_OUT        = 7'b1000000
   } state_type;

   state_type    state_ff, state_in;
   logic [15:0]  cal_ff, cal_in;
   logic [14:0]  one_g_ff, one_g_in;
   logic [15:0]  cnt_ff, cnt_in;
   logic [15:0]  n_ff, n_in;
   logic         calib_ff, calib_in;
   logic         pstart_ff, pstart_in;
   logic         rvalid_ff, rvalid_in;
   logic [151:0] rdata_ff, rdata_in;
   logic         rcal_ff, rcal_in;

   logic         accept, cfg_wr, load;
   logic [15:0]  cnt_inc;
   logic         run_done;
   lane_ctl_type ctl;

   logic signed [CORR_W-1:0] lane_corr [NUM_AXES];
   logic [SQ_W-1:0]          lane_sq [3];
   logic [NUM_AXES-1:0]      lane_busy;

   logic                 mag_start, yz_start, roll_start, pitch_start;
   logic [RAD_W-1:0]     mag_rad, yz_rad;
   logic [ROOT_W-1:0]    mag_root, yz_root;
   logic                 mag_busy, yz_busy, roll_busy, pitch_busy;
   logic signed [ARG_W-1:0]  roll_y, roll_x, pitch_y, pitch_x;
   logic signed [ZACC_W-1:0] roll_ang, pitch_ang;
   logic signed [17:0]       neg_x;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = state_ff == ST_IDLE;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cnt_inc    = cnt_ff + 16'd1;
   assign run_done   = cnt_inc != 16'd0 && cnt_inc >= cal_ff;

   always_comb begin
      ctl.acc_en    = accept && req_tuser[0];
      ctl.corr_en   = accept && !req_tuser[0];
      ctl.sq_en     = state_ff == ST_SQ;
      ctl.div_start = state_ff == ST_DIV_START;
   end

   generate
      for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
         logic [SQ_W-1:0] sq_k;
         imc_lane #(.WITH_SQUARE(k < 3)) u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctl    (ctl),
            .raw    ($signed(req_tdata[16*k +: 16])),
            .count  (n_ff),
            .bias   ((k == 2) ? one_g_ff : 15'd0),
            .corr   (lane_corr[k]),
            .square (sq_k),
            .busy   (lane_busy[k])
         );
         if (k < 3) begin : g_acc
            assign lane_sq[k] = sq_k;
         end
      end
   endgenerate

   always_comb begin
      mag_rad = RAD_W'(35'(lane_sq[0]) + 35'(lane_sq[1]) + 35'(lane_sq[2]));
      yz_rad  = RAD_W'(34'(lane_sq[1]) + 34'(lane_sq[2])) << (2 * ARG_SHIFT);
      roll_y  = ARG_W'(lane_corr[1]) <<< ARG_SHIFT;
      roll_x  = ARG_W'(lane_corr[2]) <<< ARG_SHIFT;
      neg_x   = -18'(lane_corr[0]);
      pitch_y = ARG_W'(neg_x) <<< ARG_SHIFT;
      pitch_x = $signed(ARG_W'(yz_root));
   end

   assign mag_start   = state_ff == ST_MATH_START;
   assign yz_start    = mag_start;
   assign roll_start  = mag_start;
   assign pitch_start = state_ff == ST_MATH_WAIT && !yz_busy && !pstart_ff;

   imc_isqrt u_mag_sqrt (
      .clock (clock), .reset (reset), .start (mag_start),
      .radicand (mag_rad), .busy (mag_busy), .root (mag_root)
   );

   imc_isqrt u_yz_sqrt (
      .clock (clock), .reset (reset), .start (yz_start),
      .radicand (yz_rad), .busy (yz_busy), .root (yz_root)
   );

   imc_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS), .CORDIC_STEPS (CORDIC_STEPS), .LIMIT_DEG (180)
   ) u_roll (
      .clock (clock), .reset (reset), .start (roll_start),
      .y_arg (roll_y), .x_arg (roll_x), .busy (roll_busy), .angle (roll_ang)
   );

   imc_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS), .CORDIC_STEPS (CORDIC_STEPS), .LIMIT_DEG (90)
   ) u_pitch (
      .clock (clock), .reset (reset), .start (pitch_start),
      .y_arg (pitch_y), .x_arg (pitch_x), .busy (pitch_busy), .angle (pitch_ang)
   );

   always_comb begin
      state_in  = state_ff;
      cal_in    = cal_ff;
      one_g_in  = one_g_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      calib_in  = calib_ff;
      pstart_in = pstart_ff;
      rdata_in  = rdata_ff;
      rcal_in   = rcal_ff;
      load      = 1'b0;

      if (cfg_wr) begin
         case (csr_paddr[2])
            REG_CAL_SAMPLES: cal_in   = csr_pwdata[15:0];
            REG_ONE_G:       one_g_in = csr_pwdata[14:0];
            default:         cal_in   = cal_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0]) begin
                  n_in = cnt_inc;
                  if (run_done) begin
                     cnt_in   = '0;
                     state_in = ST_DIV_START;
                  end else begin
                     cnt_in = cnt_inc;
                  end
               end else begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_DIV_START: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (lane_busy == '0) begin
               calib_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SQ: state_in = ST_MATH_START;
         ST_MATH_START: begin
            pstart_in = 1'b0;
            state_in  = ST_MATH_WAIT;
         end
         ST_MATH_WAIT: begin
            if (pitch_start) begin
               pstart_in = 1'b1;
            end
            if (pstart_ff && !pitch_busy && !roll_busy && !mag_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rvalid_ff || rsp_tready) begin
               load     = 1'b1;
               rdata_in = {2'b00, pitch_ang[14:0], roll_ang[15:0], mag_root[16:0],
                           lane_corr[5], lane_corr[4], lane_corr[3],
                           lane_corr[2], lane_corr[1], lane_corr[0]};
               rcal_in  = calib_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load) begin
         rvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rvalid_in = 1'b0;
      end else begin
         rvalid_in = rvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cal_ff    <= 16'd100;
         one_g_ff  <= 15'd16384;
         cnt_ff    <= '0;
         calib_ff  <= 1'b0;
         pstart_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cal_ff    <= cal_in;
         one_g_ff  <= one_g_in;
         cnt_ff    <= cnt_in;
         calib_ff  <= calib_in;
         pstart_ff <= pstart_in;
         rvalid_ff <= rvalid_in;
      end
      n_ff     <= n_in;
      rdata_ff <= rdata_in;
      rcal_ff  <= rcal_in;
   end

   assign csr_prdata = csr_paddr[2] ? {17'd0, one_g_ff} : {16'd0, cal_ff};
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = rcal_ff;

endmodule

/* rtl/imc_lane.sv */
module imc_lane import imc_pkg::*; #(
   parameter bit WITH_SQUARE = 1'b1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctl_type             ctl,
   input  logic signed [RAW_W-1:0]  raw,
   input  logic [15:0]              count,
   input  logic [14:0]              bias,
   output logic signed [CORR_W-1:0] corr,
   output logic [SQ_W-1:0]          square,
   output logic                     busy
);

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [CORR_W-1:0] off_ff, off_in;
   logic signed [CORR_W-1:0] corr_ff, corr_in;
   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [15:0]              rem_ff, rem_in;
   logic [5:0]               cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     neg_ff, neg_in;

   logic [SUM_W-1:0]         mag;
   logic [16:0]              rem_shift;
   logic                     ge;
   logic signed [17:0]       mean;
   logic signed [17:0]       diff;

   always_comb begin
      sum_in  = sum_ff;
      off_in  = off_ff;
      corr_in = corr_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;

      mag       = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      ge        = rem_shift >= {1'b0, count};
      mean      = '0;
      diff      = 18'(raw) - 18'(off_ff);

      if (ctl.acc_en) begin
         sum_in = sum_ff + SUM_W'(raw);
      end
      if (ctl.div_start) begin
         sum_in  = '0;
         neg_in  = sum_ff[SUM_W-1];
         quo_in  = mag[DIV_W-1:0] + DIV_W'(count[15:1]);
         rem_in  = '0;
         cnt_in  = 6'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? 16'(rem_shift - {1'b0, count}) : rem_shift[15:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            mean    = neg_ff ? -18'(quo_in[16:0]) : 18'(quo_in[16:0]);
            off_in  = CORR_W'(mean - 18'(bias));
         end
      end

      if (ctl.corr_en) begin
         if (diff > 18'sd65535) begin
            corr_in = 17'sd65535;
         end else if (diff < -18'sd65536) begin
            corr_in = -17'sd65536;
         end else begin
            corr_in = diff[CORR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         off_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         off_ff  <= off_in;
         busy_ff <= busy_in;
      end
      corr_ff <= corr_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
   end

   generate
      if (WITH_SQUARE) begin : g_sq
         logic [SQ_W-1:0]          sq_ff, sq_in;
         logic signed [2*CORR_W-1:0] prod;
         always_comb begin
            prod  = corr_ff * corr_ff;
            sq_in = ctl.sq_en ? prod[SQ_W-1:0] : sq_ff;
         end
         always_ff @(posedge clock) begin
            sq_ff <= sq_in;
         end
         assign square = sq_ff;
      end else begin : g_nosq
         assign square = '0;
      end
   endgenerate

   assign corr = corr_ff;
   assign busy = busy_ff;

endmodule

/* rtl/imc_isqrt.sv */
module imc_isqrt import imc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              busy,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0] v_ff, v_in;
   logic [RAD_W-1:0] r_ff, r_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic [RAD_W-1:0] trial;

   always_comb begin
      v_in   = v_ff;
      r_in   = r_ff;
      bit_in = bit_ff;
      trial  = r_ff + bit_ff;
      if (start) begin
         v_in   = radicand;
         r_in   = '0;
         bit_in = RAD_W'(1) << (RAD_W - 2);
      end else if (bit_ff != '0) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else begin
         bit_ff <= bit_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
   end

   assign busy = bit_ff != '0;
   assign root = r_ff[ROOT_W-1:0];

endmodule

/* rtl/imc_cordic.sv */
module imc_cordic import imc_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int CORDIC_STEPS    = 16,
   parameter int LIMIT_DEG       = 180
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ARG_W-1:0]  y_arg,
   input  logic signed [ARG_W-1:0]  x_arg,
   output logic                     busy,
   output logic signed [ZACC_W-1:0] angle
);

   localparam int SH     = 16 - ANGLE_FRAC_BITS;
   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic signed [ZACC_W-1:0] LIM     = ZACC_W'(LIMIT_DEG * (1 << ANGLE_FRAC_BITS));
   localparam logic signed [ZACC_W-1:0] HALF    = ZACC_W'(1 << (SH - 1));
   localparam logic signed [ZACC_W-1:0] QUARTER = ZACC_W'(90 * 65536);

   logic signed [ARG_W-1:0]  x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ZACC_W-1:0] z_ff, z_in, tab, zr, zs;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     busy_ff, busy_in;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      tab     = $signed(ZACC_W'(atan_entry(5'(step_ff))));
      if (start) begin
         busy_in = !(x_arg == '0 && y_arg == '0);
         step_in = '0;
         if (x_arg < 0) begin
            if (y_arg >= 0) begin
               x_in = y_arg;
               y_in = -x_arg;
               z_in = QUARTER;
            end else begin
               x_in = -y_arg;
               y_in = x_arg;
               z_in = -QUARTER;
            end
         end else begin
            x_in = x_arg;
            y_in = y_arg;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + tab;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - tab;
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

   always_comb begin
      zr = z_ff + HALF;
      zs = zr >>> SH;
      if (zs > LIM) begin
         angle = LIM;
      end else if (zs < -LIM) begin
         angle = -LIM;
      end else begin
         angle = zs;
      end
   end

   assign busy = busy_ff;

endmodule

/* rtl/imc_checker.sv */
module imc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [151:0] rsp_tdata
);

   // A measure item keeps the block busy for the following cycle at least.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser[0] |=> !req_tready)
      else $error("input accepted right after a measure item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind imu_offset_calibrate_and_tilt imc_checker u_imc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/tb_imu_offset_calibrate_and_tilt.sv */
module tb_imu_offset_calibrate_and_tilt;
   import imc_pkg::*;

   localparam int ANGLE_FRAC = 7;
   localparam int TILT_STEPS = 16;
   localparam int REG_CAL_SAMPLES = 0;
   localparam int REG_ONE_G = 1;
   localparam bit ACT_MEASURE = 1'b0;
   localparam bit ACT_CALIBRATE = 1'b1;
   localparam int DRAIN_CYCLES = 100;
   localparam longint CYCLE_LIMIT = 2000000;
   localparam longint ATAN_DEG16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   typedef struct {
      logic [16:0] corr [6];
      logic [16:0] mag;
      logic [15:0] roll;
      logic [14:0] pitch;
      logic        cal;
   } tilt_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   tilt_result_type expected_tilt [$];
   int             errors = 0;
   int             items_sent = 0;
   int             burst_left = 0;
   int             stall_mode = 0;
   longint         cycles = 0;

   longint         axis_sum [6];
   longint         axis_offset [6];
   int unsigned    cal_count;
   bit             cal_done;
   int unsigned    cal_samples_reg;
   int unsigned    one_g_reg;

   imu_offset_calibrate_and_tilt #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC),
      .CORDIC_STEPS(TILT_STEPS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("imu_offset_calibrate_and_tilt regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
      if (stall_mode == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, stall_mode) == 0);
      end
   end

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint tilt_angle(longint y, longint x, longint limit_deg);
      longint z;
      longint t;
      longint nx;
      longint ny;
      longint ang;
      longint lim;
      int sh;
      sh = 16 - ANGLE_FRAC;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = 90 * 65536;
         end else begin
            x = -y;
            y = t;
            z = -90 * 65536;
         end
      end
      for (int i = 0; i < TILT_STEPS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z = z + ATAN_DEG16[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z = z - ATAN_DEG16[i];
         end
         x = nx;
         y = ny;
      end
      ang = (z + (longint'(1) <<< (sh - 1))) >>> sh;
      lim = limit_deg * (longint'(1) <<< ANGLE_FRAC);
      if (ang > lim) ang = lim;
      if (ang < -lim) ang = -lim;
      return ang;
   endfunction

   function automatic longint mean_rounded(longint sum, longint n);
      longint mag;
      longint q;
      mag = (sum < 0) ? -sum : sum;
      q = (mag + n / 2) / n;
      return (sum < 0) ? -q : q;
   endfunction

   task automatic update_tilt_model(input bit act, input logic signed [15:0] raw [6]);
      longint c [6];
      longint yz;
      tilt_result_type res;
      if (act == ACT_CALIBRATE) begin
         for (int k = 0; k < 6; k++) axis_sum[k] += raw[k];
         cal_count = (cal_count + 1) & 16'hFFFF;
         if (cal_count != 0 && cal_count >= cal_samples_reg) begin
            for (int k = 0; k < 6; k++) axis_offset[k] = mean_rounded(axis_sum[k], cal_count);
            axis_offset[2] -= one_g_reg;
            for (int k = 0; k < 6; k++) axis_sum[k] = 0;
            cal_count = 0;
            cal_done = 1'b1;
         end
      end else begin
         for (int k = 0; k < 6; k++) begin
            c[k] = raw[k] - axis_offset[k];
            if (c[k] > 65535) c[k] = 65535;
            if (c[k] < -65536) c[k] = -65536;
            res.corr[k] = c[k][16:0];
         end
         res.mag = 17'(floor_root(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]));
         yz = floor_root((c[1] * c[1] + c[2] * c[2]) << 28);
         res.roll = 16'(tilt_angle(c[1] <<< ARG_SHIFT, c[2] <<< ARG_SHIFT, 180));
         res.pitch = 15'(tilt_angle(-(c[0] <<< ARG_SHIFT), yz, 90));
         res.cal = cal_done;
         expected_tilt.push_back(res);
      end
   endtask

   always @(negedge clock) begin
      tilt_result_type e;
      logic [16:0] got [6];
      if (!reset && rsp_tvalid && rsp_tready) begin
         for (int k = 0; k < 6; k++) got[k] = rsp_tdata[17*k +: 17];
         if (expected_tilt.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = expected_tilt.pop_front();
            for (int k = 0; k < 6; k++) begin
               if (got[k] !== e.corr[k]) begin
                  $display("%0t: axis %0d expected %h actual %h", $time, k, e.corr[k], got[k]);
                  errors++;
               end
            end
            if (rsp_tdata[118:102] !== e.mag) begin
               $display("%0t: magnitude expected %h actual %h", $time, e.mag, rsp_tdata[118:102]);
               errors++;
            end
            if (rsp_tdata[134:119] !== e.roll) begin
               $display("%0t: roll expected %h actual %h", $time, e.roll, rsp_tdata[134:119]);
               errors++;
            end
            if (rsp_tdata[149:135] !== e.pitch) begin
               $display("%0t: pitch expected %h actual %h", $time, e.pitch, rsp_tdata[149:135]);
               errors++;
            end
            if (rsp_tuser[0] !== e.cal) begin
               $display("%0t: calibrated expected %b actual %b", $time, e.cal, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   task automatic send_sample(input bit act, input logic signed [15:0] raw [6]);
      bit ok;
      if (burst_left == 0) begin
         if (req_tvalid) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {raw[5], raw[4], raw[3], raw[2], raw[1], raw[0]};
      forever begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
         if (ok) break;
      end
      update_tilt_model(act, raw);
      burst_left--;
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_tilt.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_register(input int idx, input int unsigned value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_CAL_SAMPLES) cal_samples_reg = value & 16'hFFFF;
      else one_g_reg = value & 15'h7FFF;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_raw();
      case ($urandom_range(0, 7))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_uniform(input bit act, input logic signed [15:0] v);
      logic signed [15:0] raw [6];
      foreach (raw[k]) raw[k] = v;
      send_sample(act, raw);
   endtask

   task automatic send_tilt(input logic signed [15:0] ax, input logic signed [15:0] ay,
                            input logic signed [15:0] az);
      logic signed [15:0] raw [6];
      raw = '{ax, ay, az, pick_raw(), pick_raw(), pick_raw()};
      send_sample(ACT_MEASURE, raw);
   endtask

   task automatic test_uncalibrated_measures();
      send_uniform(ACT_MEASURE, 16'sd0);
      send_uniform(ACT_MEASURE, 16'sd32767);
      send_uniform(ACT_MEASURE, -16'sd32768);
      send_tilt(16'sd500, 16'sd0, -16'sd100);
      send_tilt(-16'sd500, -16'sd5, -16'sd100);
      send_tilt(16'sd700, 16'sd9, -16'sd100);
      send_tilt(16'sd32767, 16'sd0, 16'sd0);
      send_tilt(-16'sd32768, 16'sd0, 16'sd0);
      send_tilt(16'sd0, 16'sd16384, 16'sd0);
      send_tilt(16'sd0, -16'sd16384, 16'sd1);
   endtask

   task automatic test_calibration_extremes();
      drain_results();
      write_register(REG_CAL_SAMPLES, 1);
      write_register(REG_ONE_G, 32767);
      send_uniform(ACT_CALIBRATE, -16'sd32768);
      send_uniform(ACT_MEASURE, 16'sd32767);
      send_uniform(ACT_MEASURE, -16'sd32768);
      drain_results();
      write_register(REG_CAL_SAMPLES, 0);
      write_register(REG_ONE_G, 1);
      send_uniform(ACT_CALIBRATE, 16'sd32767);
      send_uniform(ACT_MEASURE, -16'sd32768);
      drain_results();
      write_register(REG_CAL_SAMPLES, 65535);
      send_uniform(ACT_CALIBRATE, 16'sd3);
      send_uniform(ACT_CALIBRATE, 16'sd4);
      send_uniform(ACT_MEASURE, 16'sd100);
      drain_results();
      // Lowering the sample count mid-run closes the run on the next item.
      write_register(REG_CAL_SAMPLES, 2);
      send_uniform(ACT_CALIBRATE, -16'sd7);
      send_uniform(ACT_MEASURE, 16'sd100);
      send_tilt(16'sd20, 16'sd0, -16'sd16384);
   endtask

   task automatic test_random_runs(input int target);
      logic signed [15:0] raw [6];
      logic signed [15:0] base [6];
      int n;
      int next_cfg;
      bit paused;
      next_cfg = items_sent + 200;
      paused = 1'b0;
      while (items_sent < target) begin
         if (items_sent >= next_cfg) begin
            drain_results();
            write_register(REG_CAL_SAMPLES, ($urandom_range(0, 9) == 0) ?
                           $urandom_range(7, 20) : $urandom_range(1, 6));
            write_register(REG_ONE_G, ($urandom_range(0, 1) == 0) ? 16384 :
                           $urandom_range(1, 32767));
            next_cfg = items_sent + 200;
         end
         if (!paused && items_sent > target / 2) begin
            drain_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 4) != 0) begin
            foreach (base[k]) base[k] = pick_raw();
            n = (cal_samples_reg == 0) ? 1 : cal_samples_reg - cal_count;
            if (n > 20) n = 20;
            repeat (n) begin
               foreach (raw[k]) raw[k] = base[k] + 16'($signed($urandom_range(0, 64)) - 32);
               send_sample(ACT_CALIBRATE, raw);
            end
            repeat ($urandom_range(3, 10)) begin
               foreach (raw[k]) raw[k] = ($urandom_range(0, 3) == 0) ? pick_raw() :
                                         base[k] + 16'($signed($urandom_range(0, 4000)) - 2000);
               send_sample(ACT_MEASURE, raw);
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               foreach (raw[k]) raw[k] = pick_raw();
               send_sample(($urandom_range(0, 3) == 0) ? ACT_CALIBRATE : ACT_MEASURE, raw);
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      foreach (axis_sum[k]) begin
         axis_sum[k] = 0;
         axis_offset[k] = 0;
      end
      cal_count = 0;
      cal_done = 1'b0;
      cal_samples_reg = 100;
      one_g_reg = 16384;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_uncalibrated_measures();
      test_calibration_extremes();
      test_random_runs(1650);
      req_tvalid <= 1'b0;
      while (expected_tilt.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("imu_offset_calibrate_and_tilt regression: pass");
      end else begin
         $display("imu_offset_calibrate_and_tilt regression: fail");
      end
      $finish;
   end

endmodule
